[rtl/bit_slice_field_reader_assert.svh]
`ifndef BIT_SLICE_FIELD_READER_ASSERT_SVH
`define BIT_SLICE_FIELD_READER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BSFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsfr assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define BSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsfr assertion failed");

`endif

[rtl/bsfr_pkg.sv]
package bsfr_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int FIELD_MAX_BITS   = 64;
  localparam int SIZE_VALUE_BITS  = 16;
  localparam int BYTE_BITS        = 8;
  localparam int POS_W            = 11;
  localparam int ACC_W            = FIELD_MAX_BITS + BYTE_BITS;

  localparam logic [2:0] MODE_LOAD       = 3'd0;
  localparam logic [2:0] MODE_SLICE      = 3'd1;
  localparam logic [2:0] MODE_PEEK       = 3'd2;
  localparam logic [2:0] MODE_TAKE       = 3'd3;
  localparam logic [2:0] MODE_TAKE_SIZED = 3'd4;
  localparam logic [2:0] MODE_SKIP       = 3'd5;
  localparam logic [2:0] MODE_TRUNC      = 3'd6;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_SLICE     = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       first;
    logic [2:0] lead;
    logic [2:0] tail;
  } sh_ctrl_t;

  function automatic logic [4:0] bit_length16(input logic [SIZE_VALUE_BITS-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < SIZE_VALUE_BITS; i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[rtl/bsfr_ram.sv]
module bsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bsfr_shifter.sv]
module bsfr_shifter (
  input  logic              clk,
  input  bsfr_pkg::sh_ctrl_t ctrl,
  input  logic [7:0]        din,
  output logic [63:0]       value
);

  import bsfr_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] aligned;
  logic [7:0]       din_masked;

  // drop the bits ahead of the field in its first byte
  assign din_masked = ctrl.first ? (din & (8'hFF >> ctrl.lead)) : din;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.shift) begin
      acc <= {acc[ACC_W-BYTE_BITS-1:0], din_masked};
    end
  end

  // drop the bits past the field in its last byte
  assign aligned = acc >> ctrl.tail;
  assign value   = aligned[FIELD_MAX_BITS-1:0];

endmodule

[rtl/bit_slice_field_reader.sv]
// channel  | valid / stall          | payload
// request  | req_valid / req_stall  | mode address byte_value slice_bytes position
//          |                        | field_bits size_value
// result   | rsp_valid / rsp_stall  | value error_code remaining cursor empty_res
//
// One request at a time. A request that reads no field passes S_EVAL then S_FIN;
// a field read spans nb bytes (1 to 9) and passes S_EVAL, S_READ and S_FIN, with
// the byte store's single read port delivering one byte per cycle in S_READ.
// rst is synchronous and clears the window to empty; store contents are kept.
// A stalled result holds; a new request is taken while it waits.
`include "bit_slice_field_reader_assert.svh"

module bit_slice_field_reader #(
  parameter int BUFFER_BYTES = bsfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  mode,
  input  logic [6:0]  address,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  slice_bytes,
  input  logic [10:0] position,
  input  logic [6:0]  field_bits,
  input  logic [15:0] size_value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [63:0] value,
  output logic [1:0]  error_code,
  output logic [10:0] remaining,
  output logic [10:0] cursor,
  output logic        empty_res
);

  import bsfr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_READ = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  logic [2:0]       r_mode;
  logic [6:0]       r_address;
  logic [7:0]       r_byte_value;
  logic [7:0]       r_slice_bytes;
  logic [POS_W-1:0] r_position;
  logic [6:0]       r_field_bits;
  logic [15:0]      r_size_value;

  logic [POS_W-1:0] wstart;
  logic [POS_W-1:0] wend;
  logic [1:0]       err;
  logic [1:0]       err_next;
  logic             go_read;

  logic [AW-1:0]    rd_addr;
  logic [3:0]       issue_left;
  logic [3:0]       recv_left;
  logic             pend;
  logic             first;
  logic [2:0]       lead;
  logic [2:0]       tail;

  logic [POS_W-1:0] bits_left;
  logic [4:0]       sized_bits;
  logic [6:0]       rd_width;
  logic [POS_W-1:0] rd_offset;
  logic             is_read;
  logic [POS_W:0]   rd_end;
  logic             rd_err;
  logic [POS_W-1:0] rd_pos;
  logic [7:0]       span;
  logic [7:0]       span_up;
  logic             skip_err;
  logic             trunc_err;
  logic             slice_err;
  logic             load_ok;
  logic             out_free;

  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  sh_ctrl_t         sh_ctrl;
  logic [63:0]      sh_value;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign bits_left  = (wstart < wend) ? (wend - wstart) : '0;
  assign sized_bits = bit_length16(r_size_value);
  assign rd_width   = (r_mode == MODE_TAKE_SIZED) ? {2'b0, sized_bits} : r_field_bits;
  assign rd_offset  = (r_mode == MODE_PEEK) ? r_position : '0;
  assign is_read    = (r_mode == MODE_PEEK) || (r_mode == MODE_TAKE) ||
                      ((r_mode == MODE_TAKE_SIZED) && (r_size_value != '0));
  assign rd_end     = {1'b0, rd_offset} + {5'b0, rd_width};
  assign rd_err     = (rd_width > 7'(FIELD_MAX_BITS)) || (rd_end > {1'b0, bits_left});
  assign rd_pos     = wstart + rd_offset;
  assign span       = {5'b0, rd_pos[2:0]} + {1'b0, rd_width};
  assign span_up    = span + 8'd7;
  assign skip_err   = ({1'b0, wstart} + {1'b0, r_position}) > {1'b0, wend};
  assign trunc_err  = r_position > wend;
  assign slice_err  = int'(r_slice_bytes) > BUFFER_BYTES;
  assign load_ok    = int'(r_address) < BUFFER_BYTES;
  assign go_read    = is_read && !rd_err && (rd_width != '0);

  always_comb begin
    err_next = ERR_NONE;
    case (r_mode) inside
      MODE_PEEK, MODE_TAKE, MODE_TAKE_SIZED: begin
        if (is_read && rd_err) begin
          err_next = ERR_UNDERFLOW;
        end
      end
      MODE_SLICE: begin
        if (slice_err) begin
          err_next = ERR_SLICE;
        end
      end
      MODE_SKIP: begin
        if (skip_err) begin
          err_next = ERR_UNDERFLOW;
        end
      end
      MODE_TRUNC: begin
        if (trunc_err) begin
          err_next = ERR_UNDERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we = (state == S_EVAL) && (r_mode == MODE_LOAD) && load_ok;
  assign ram_re = (state == S_READ) && (issue_left != '0);

  assign sh_ctrl.clear = (state == S_EVAL);
  assign sh_ctrl.shift = (state == S_READ) && pend;
  assign sh_ctrl.first = first;
  assign sh_ctrl.lead  = lead;
  assign sh_ctrl.tail  = tail;

  bsfr_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(r_address)),
    .wdata (r_byte_value),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  bsfr_shifter u_shifter (
    .clk   (clk),
    .ctrl  (sh_ctrl),
    .din   (ram_rdata),
    .value (sh_value)
  );

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      r_mode        <= mode;
      r_address     <= address;
      r_byte_value  <= byte_value;
      r_slice_bytes <= slice_bytes;
      r_position    <= position;
      r_field_bits  <= field_bits;
      r_size_value  <= size_value;
    end
    if (state == S_EVAL) begin
      rd_addr    <= AW'(rd_pos[POS_W-1:3]);
      issue_left <= span_up[6:3];
      recv_left  <= span_up[6:3];
      lead       <= rd_pos[2:0];
      tail       <= 3'd0 - span[2:0];
    end else if (ram_re) begin
      rd_addr    <= rd_addr + AW'(1);
      issue_left <= issue_left - 4'd1;
    end
    if (sh_ctrl.shift) begin
      recv_left <= recv_left - 4'd1;
    end
    if (state == S_FIN && out_free) begin
      value      <= sh_value;
      error_code <= err;
      remaining  <= bits_left;
      cursor     <= wstart;
      empty_res  <= (wstart >= wend);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wstart    <= '0;
      wend      <= '0;
      err       <= ERR_NONE;
      pend      <= 1'b0;
      first     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          err   <= err_next;
          pend  <= 1'b0;
          first <= 1'b1;
          state <= go_read ? S_READ : S_FIN;
          case (r_mode) inside
            MODE_PEEK, MODE_TAKE, MODE_TAKE_SIZED: begin
              if (is_read && !rd_err && (r_mode != MODE_PEEK)) begin
                wstart <= wstart + {4'b0, rd_width};
              end
            end
            MODE_SLICE: begin
              if (!slice_err) begin
                wstart <= '0;
                wend   <= {r_slice_bytes, 3'b0};
              end
            end
            MODE_SKIP: begin
              if (!skip_err) begin
                wstart <= wstart + r_position;
              end
            end
            MODE_TRUNC: begin
              if (!trunc_err) begin
                wend <= r_position;
              end
            end
            default: begin
            end
          endcase
        end
        S_READ: begin
          pend <= ram_re;
          if (pend) begin
            first <= 1'b0;
            if (recv_left == 4'd1) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSFR_ASSERT_IMPL(a_err_zero_value, rsp_valid, (error_code == ERR_NONE) || (value == '0))
  `BSFR_ASSERT_IMPL(a_empty_match, rsp_valid, empty_res == (remaining == '0))
  `BSFR_ASSERT_IMPL(a_issue_le_recv, state == S_READ, issue_left <= recv_left)
  `BSFR_ASSERT_IMPL(a_pend_in_read, pend, state == S_READ)
  `BSFR_ASSERT_NEXT(a_accept_eval, req_valid && !req_stall, state == S_EVAL)

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfr_pkg::*;

  localparam int STORE_BYTES = BUFFER_BYTES_DEF;
  localparam logic [2:0] MODE_NOP = 3'd7;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_AT = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE_AT = 400;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  address;
    logic [7:0]  byte_value;
    logic [7:0]  slice_bytes;
    logic [10:0] position;
    logic [6:0]  field_bits;
    logic [15:0] size_value;
  } request_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  error_code;
    logic [10:0] remaining;
    logic [10:0] cursor;
    logic        empty_res;
  } result_t;

  class field_reader_scoreboard;
    logic [7:0]  store [STORE_BYTES];
    bit          written [STORE_BYTES];
    int unsigned win_start;
    int unsigned win_end;
    result_t     expected_q[$];
    int          failures;

    function int unsigned bits_left();
      return (win_start < win_end) ? win_end - win_start : 0;
    endfunction

    function int unsigned size_bits(logic [15:0] v);
      int unsigned n;
      n = 0;
      while (v != 0) begin
        n++;
        v = v >> 1;
      end
      return n;
    endfunction

    function logic [63:0] gather(int unsigned from, int unsigned width);
      logic [63:0] acc;
      int unsigned p;
      acc = '0;
      for (int unsigned i = 0; i < width; i++) begin
        p = from + i;
        acc = {acc[62:0],
               (p / BYTE_BITS < STORE_BYTES) ? store[p / BYTE_BITS][7 - p % BYTE_BITS] : 1'b0};
      end
      return acc;
    endfunction

    function logic [1:0] extract(int unsigned offset, int unsigned width, bit advance,
                                 output logic [63:0] got);
      got = '0;
      if (width > FIELD_MAX_BITS || offset + width > bits_left()) return ERR_UNDERFLOW;
      got = gather(win_start + offset, width);
      if (advance) win_start += width;
      return ERR_NONE;
    endfunction

    // first store byte that a read request would touch before it was ever loaded
    function int first_blank_byte(request_t r);
      int unsigned from;
      int unsigned width;
      case (r.mode)
        MODE_PEEK: begin
          from = win_start + r.position;
          width = r.field_bits;
        end
        MODE_TAKE: begin
          from = win_start;
          width = r.field_bits;
        end
        MODE_TAKE_SIZED: begin
          from = win_start;
          width = size_bits(r.size_value);
        end
        default: return -1;
      endcase
      if (width > FIELD_MAX_BITS) width = FIELD_MAX_BITS;
      for (int unsigned b = from / BYTE_BITS;
           b * BYTE_BITS < from + width && b < STORE_BYTES; b++) begin
        if (!written[b]) return b;
      end
      return -1;
    endfunction

    function void note_request(request_t r);
      result_t e;
      logic [63:0] got;
      e = '0;
      got = '0;
      case (r.mode)
        MODE_LOAD: begin
          if (r.address < STORE_BYTES) begin
            store[r.address] = r.byte_value;
            written[r.address] = 1'b1;
          end
        end
        MODE_SLICE: begin
          if (r.slice_bytes > STORE_BYTES) begin
            e.error_code = ERR_SLICE;
          end else begin
            win_start = 0;
            win_end = r.slice_bytes * BYTE_BITS;
          end
        end
        MODE_PEEK: e.error_code = extract(r.position, r.field_bits, 1'b0, got);
        MODE_TAKE: e.error_code = extract(0, r.field_bits, 1'b1, got);
        MODE_TAKE_SIZED: begin
          if (r.size_value != 0) e.error_code = extract(0, size_bits(r.size_value), 1'b1, got);
        end
        MODE_SKIP: begin
          if (win_start + r.position > win_end) e.error_code = ERR_UNDERFLOW;
          else win_start += r.position;
        end
        MODE_TRUNC: begin
          if (r.position > win_end) e.error_code = ERR_UNDERFLOW;
          else win_end = r.position;
        end
        default: ;
      endcase
      e.value = (e.error_code == ERR_NONE) ? got : '0;
      e.remaining = 11'(bits_left());
      e.cursor = 11'(win_start);
      e.empty_res = (win_start >= win_end);
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t act);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        failures++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("value", e.value, act.value);
      compare_field("error_code", e.error_code, act.error_code);
      compare_field("remaining", e.remaining, act.remaining);
      compare_field("cursor", e.cursor, act.cursor);
      compare_field("empty_res", e.empty_res, act.empty_res);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  mode = '0;
  logic [6:0]  address = '0;
  logic [7:0]  byte_value = '0;
  logic [7:0]  slice_bytes = '0;
  logic [10:0] position = '0;
  logic [6:0]  field_bits = '0;
  logic [15:0] size_value = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [63:0] value;
  logic [1:0]  error_code;
  logic [10:0] remaining;
  logic [10:0] cursor;
  logic        empty_res;

  field_reader_scoreboard sb = new;
  int unsigned items_accepted = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  bit_slice_field_reader uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .address(address), .byte_value(byte_value), .slice_bytes(slice_bytes),
    .position(position), .field_bits(field_bits), .size_value(size_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .value(value), .error_code(error_code), .remaining(remaining), .cursor(cursor),
    .empty_res(empty_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // result side: check, then pick next stall; one long hold-off to back up the block
  initial begin : result_side
    int unsigned hold_left;
    bit hold_done;
    result_t got;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        got = {value, error_code, remaining, cursor, empty_res};
        sb.check_result(got);
      end
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic request_t make_req(logic [2:0] m, logic [6:0] a, logic [7:0] bv,
                                        logic [7:0] sl, logic [10:0] p, logic [6:0] fb,
                                        logic [15:0] sv);
    request_t r;
    r = '{mode: m, address: a, byte_value: bv, slice_bytes: sl, position: p,
          field_bits: fb, size_value: sv};
    return r;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.mode = 3'($urandom_range(0, 7));
    r.address = 7'($urandom());
    r.byte_value = 8'($urandom());
    r.slice_bytes = 8'($urandom());
    r.position = 11'($urandom());
    r.field_bits = 7'($urandom());
    r.size_value = 16'($urandom());
    return r;
  endfunction

  task automatic send_request(request_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= r.mode;
    address <= r.address;
    byte_value <= r.byte_value;
    slice_bytes <= r.slice_bytes;
    position <= r.position;
    field_bits <= r.field_bits;
    size_value <= r.size_value;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    if (r.mode != MODE_NOP) items_accepted++;
  endtask

  // reads over never-loaded bytes are turned into a load of that byte
  task automatic issue(request_t r);
    int blank;
    blank = sb.first_blank_byte(r);
    if (blank >= 0) begin
      r.mode = MODE_LOAD;
      r.address = 7'(blank);
    end
    send_request(r);
  endtask

  task automatic run_directed();
    logic [7:0] pattern [9];
    pattern = '{8'hA5, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h5A, 8'hC3, 8'h7E, 8'h3C};
    for (int i = 0; i < 9; i++) issue(make_req(MODE_LOAD, 7'(i), pattern[i], 0, 0, 0, 0));
    issue(make_req(MODE_LOAD, 7'd127, 8'hFF, 0, 0, 0, 0));
    issue(make_req(MODE_SLICE, 0, 0, 8'd255, 0, 0, 0));
    issue(make_req(MODE_SLICE, 0, 0, 8'd9, 0, 0, 0));
    issue(make_req(MODE_PEEK, 0, 0, 0, 11'd3, 7'd64, 0));
    issue(make_req(MODE_PEEK, 0, 0, 0, 11'd9, 7'd64, 0));
    issue(make_req(MODE_TAKE, 0, 0, 0, 0, 7'd127, 0));
    issue(make_req(MODE_TAKE, 0, 0, 0, 0, 7'd0, 0));
    issue(make_req(MODE_TAKE_SIZED, 0, 0, 0, 0, 0, 16'd0));
    issue(make_req(MODE_TAKE_SIZED, 0, 0, 0, 0, 0, 16'hFFFF));
    issue(make_req(MODE_TAKE, 0, 0, 0, 0, 7'd5, 0));
    issue(make_req(MODE_SKIP, 0, 0, 0, 11'd2047, 0, 0));
    issue(make_req(MODE_SKIP, 0, 0, 0, 11'd10, 0, 0));
    issue(make_req(MODE_TRUNC, 0, 0, 0, 11'd2047, 0, 0));
    // end pulled in below the cursor
    issue(make_req(MODE_TRUNC, 0, 0, 0, 11'd20, 0, 0));
    issue(make_req(MODE_TAKE, 0, 0, 0, 0, 7'd1, 0));
    issue(make_req(MODE_NOP, 0, 0, 0, 0, 0, 0));
    issue(make_req(MODE_SLICE, 0, 0, 8'd128, 0, 0, 0));
  endtask

  task automatic run_loads();
    request_t r;
    int unsigned a;
    a = $urandom_range(0, STORE_BYTES - 1);
    repeat ($urandom_range(1, 8)) begin
      r = noise_request();
      r.mode = MODE_LOAD;
      r.address = 7'(a % STORE_BYTES);
      issue(r);
      a++;
    end
  endtask

  function automatic request_t broken_request(request_t r);
    int unsigned rem;
    int unsigned w;
    rem = sb.bits_left();
    case ($urandom_range(0, 5))
      0: begin
        r.mode = MODE_PEEK;
        r.field_bits = 7'($urandom_range(1, 64));
        r.position = 11'($urandom_range(rem, 2047));
      end
      1: begin
        r.mode = MODE_TAKE;
        r.field_bits = 7'((rem < 64) ? $urandom_range(rem + 1, 64) : $urandom_range(65, 127));
      end
      2: begin
        r.mode = $urandom_range(0, 1) ? MODE_TAKE : MODE_PEEK;
        r.field_bits = 7'($urandom_range(65, 127));
      end
      3: begin
        r.mode = MODE_SKIP;
        r.position = 11'($urandom_range(rem + 1, 2047));
      end
      4: begin
        r.mode = MODE_TRUNC;
        r.position = 11'($urandom_range(sb.win_end + 1, 2047));
      end
      default: begin
        r.mode = MODE_TAKE_SIZED;
        w = (rem < 16) ? $urandom_range(rem + 1, 16) : 16;
        r.size_value = (16'd1 << (w - 1)) | (r.size_value & ((16'd1 << (w - 1)) - 16'd1));
      end
    endcase
    return r;
  endfunction

  // open a slice, then walk through it with mostly legal reads and moves
  task automatic run_stream();
    request_t r;
    int unsigned rem;
    int unsigned w;
    int unsigned lo;
    int unsigned pick;
    r = noise_request();
    r.mode = MODE_SLICE;
    pick = $urandom_range(0, 99);
    if (pick < 5) r.slice_bytes = 0;
    else if (pick < 12) r.slice_bytes = 8'(STORE_BYTES);
    else if (pick < 22) r.slice_bytes = 8'($urandom_range(STORE_BYTES + 1, 255));
    else r.slice_bytes = 8'($urandom_range(1, STORE_BYTES));
    issue(r);
    repeat ($urandom_range(3, 14)) begin
      r = noise_request();
      rem = sb.bits_left();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        r.mode = MODE_PEEK;
        w = $urandom_range(0, (rem < 64) ? rem : 64);
        r.field_bits = 7'(w);
        r.position = 11'($urandom_range(0, rem - w));
      end else if (pick < 55) begin
        r.mode = MODE_TAKE;
        r.field_bits = 7'($urandom_range(0, (rem < 64) ? rem : 64));
      end else if (pick < 70) begin
        r.mode = MODE_TAKE_SIZED;
        w = $urandom_range(0, (rem < 16) ? rem : 16);
        r.size_value = (w == 0) ? 16'd0 :
                       ((16'd1 << (w - 1)) | (r.size_value & ((16'd1 << (w - 1)) - 16'd1)));
      end else if (pick < 80) begin
        r.mode = MODE_SKIP;
        r.position = 11'($urandom_range(0, (rem < 48) ? rem : 48));
      end else if (pick < 88) begin
        r.mode = MODE_TRUNC;
        lo = (sb.win_start < sb.win_end) ? sb.win_start : sb.win_end;
        r.position = 11'($urandom_range(lo, sb.win_end));
      end else begin
        r = broken_request(r);
      end
      issue(r);
    end
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned progress;
    int unsigned pick;
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    base = items_accepted;
    progress = 0;
    while (progress < RANDOM_ITEMS) begin
      case (progress * 4 / RANDOM_ITEMS)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 77; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 77; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (!paused && progress >= PAUSE_AT) begin
        paused = 1'b1;
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) run_loads();
      else if (pick < 22) issue(noise_request());
      else run_stream();
      progress = items_accepted - base;
    end
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
